// ===== sv/substring_occurrence_counter_top_macros.svh =====
// Assertion macros shared by the substring occurrence counter RTL.
// Included by the modules that carry concurrent checks; depends on nothing.
`ifndef SUBSTRING_OCCURRENCE_COUNTER_TOP_MACROS_SVH
`define SUBSTRING_OCCURRENCE_COUNTER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Condition that must hold at every clock edge outside reset.
`define SOC_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("soc check failed: invariant violated");
// Consequence that must hold in the cycle after the antecedent.
`define SOC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("soc check failed: next-cycle consequence violated");
`else
`define SOC_ASSERT_ALWAYS(label, clk, rst, cond)
`define SOC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== sv/soc_pkg.sv =====
// Shared types and constants for the substring occurrence counter.
// Depends on nothing; imported by every module of the block.
package soc_pkg;

   localparam int DEFAULT_MAX_PATTERN = 16;
   localparam int DEFAULT_COUNT_BITS  = 16;

   localparam int BYTE_BITS        = 8;
   localparam int PATTERN_LEN_BITS = 5;
   localparam int OCC_COUNT_BITS   = 16;
   localparam int CSR_INDEX_BITS   = 2;
   localparam int CSR_DATA_BITS    = 64;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_LOW    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_HIGH   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_LENGTH = 2'd2;

   // One accepted word as seen by the tally logic.
   typedef struct packed {
      logic accept;
      logic last;
      logic window_match;
   } step_type;

endpackage

// ===== sv/substring_occurrence_counter_top.sv =====
// Top level of the substring occurrence counter.
// Depends on soc_pkg, soc_cell and soc_tally.
//
// Usage: text arrives on the req_ channel, one byte per word, with
// req_end_of_text set on the final byte of a text. For every accepted word
// exactly one result word leaves on the rsp_ channel: whether a counted,
// non-overlapping occurrence of the pattern ends at that byte, the running
// count for the text so far (saturating), and a flag that marks the final
// count. The pattern and its length are written through the csr_ port
// while the block is idle.
// The result is registered, valid in the cycle after acceptance; while
// results are taken, one word enters every cycle, as a chain of history
// cells, each holding one earlier byte, compares the whole window at once.
// When the receiver stalls, the result stays in the output register and a
// new word is accepted only in a cycle in which that result is taken.
// Reset, synchronous and active high, clears the configuration, the text
// state and the output valid flag; req_ready stays low while it is held.
// After the final byte of a text the text state clears, while the
// configuration is kept.
module substring_occurrence_counter_top #(
   parameter int MAX_PATTERN = soc_pkg::DEFAULT_MAX_PATTERN,
   parameter int COUNT_BITS  = soc_pkg::DEFAULT_COUNT_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [soc_pkg::BYTE_BITS-1:0]      req_text_byte,
   input  logic                               req_end_of_text,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_match_found,
   output logic [soc_pkg::OCC_COUNT_BITS-1:0] rsp_occurrence_count,
   output logic                               rsp_count_final,
   input  logic                               csr_write_en,
   input  logic [soc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [soc_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import soc_pkg::*;

   localparam int IDX_BITS = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam logic [PATTERN_LEN_BITS-1:0] MAX_LEN = PATTERN_LEN_BITS'(MAX_PATTERN);

   logic [CSR_DATA_BITS-1:0]    pattern_low_ff;
   logic [CSR_DATA_BITS-1:0]    pattern_high_ff;
   logic [PATTERN_LEN_BITS-1:0] pattern_length_ff;

   logic [MAX_PATTERN-1:0][BYTE_BITS-1:0] pattern_bytes;
   logic [MAX_PATTERN-1:0][BYTE_BITS-1:0] chain;
   logic [MAX_PATTERN-1:0]                cell_ok;
   logic [PATTERN_LEN_BITS-1:0]           head_idx;
   logic                                  len_ok;
   logic                                  accept;
   step_type                              step;

   // Configuration registers; an index beyond the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         pattern_length_ff <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_PATTERN_LOW:    pattern_low_ff    <= csr_wdata;
            CSR_PATTERN_HIGH:   pattern_high_ff   <= csr_wdata;
            CSR_PATTERN_LENGTH: pattern_length_ff <= csr_wdata[PATTERN_LEN_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Pattern bytes in order, byte 0 first.
   for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_pat
      if (g < 8) begin : g_low
         assign pattern_bytes[g] = pattern_low_ff[g*BYTE_BITS +: BYTE_BITS];
      end else begin : g_high
         assign pattern_bytes[g] = pattern_high_ff[(g-8)*BYTE_BITS +: BYTE_BITS];
      end
   end

   assign accept = req_valid && req_ready;

   // An empty or overlong pattern never matches.
   assign len_ok   = (pattern_length_ff != '0) && (pattern_length_ff <= MAX_LEN);
   assign head_idx = pattern_length_ff - PATTERN_LEN_BITS'(1);

   // The incoming byte is compared with the last pattern byte at the head
   // of the chain, then enters the first history cell.
   assign chain[0]   = req_text_byte;
   assign cell_ok[0] = len_ok && (req_text_byte == pattern_bytes[head_idx[IDX_BITS-1:0]]);

   for (genvar g = 1; g < MAX_PATTERN; g++) begin : g_cell
      soc_cell #(
         .MAX_PATTERN (MAX_PATTERN),
         .POSITION    (g)
      ) u_cell (
         .clock            (clock),
         .shift_i          (accept),
         .byte_i           (chain[g-1]),
         .pattern_i        (pattern_bytes),
         .pattern_length_i (pattern_length_ff),
         .byte_o           (chain[g]),
         .match_ok_o       (cell_ok[g])
      );
   end

   assign step.accept       = accept;
   assign step.last         = req_end_of_text;
   assign step.window_match = &cell_ok;

   soc_tally #(
      .MAX_PATTERN (MAX_PATTERN),
      .COUNT_BITS  (COUNT_BITS)
   ) u_tally (
      .clock                (clock),
      .reset                (reset),
      .step_i               (step),
      .pattern_length_i     (pattern_length_ff),
      .req_ready            (req_ready),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_match_found      (rsp_match_found),
      .rsp_occurrence_count (rsp_occurrence_count),
      .rsp_count_final      (rsp_count_final)
   );

endmodule

// ===== sv/soc_cell.sv =====
// One history cell of the match chain: holds a past text byte and compares it.
// Depends on soc_pkg.
module soc_cell #(
   parameter int MAX_PATTERN = 16,
   parameter int POSITION    = 1
) (
   input  logic                                             clock,
   input  logic                                             shift_i,
   input  logic [soc_pkg::BYTE_BITS-1:0]                    byte_i,
   input  logic [MAX_PATTERN-1:0][soc_pkg::BYTE_BITS-1:0]   pattern_i,
   input  logic [soc_pkg::PATTERN_LEN_BITS-1:0]             pattern_length_i,
   output logic [soc_pkg::BYTE_BITS-1:0]                    byte_o,
   output logic                                             match_ok_o
);
   import soc_pkg::*;

   localparam int IDX_BITS = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam logic [5:0] POS     = 6'(POSITION);
   localparam logic [5:0] MAX_LEN = 6'(MAX_PATTERN);

   logic [BYTE_BITS-1:0] byte_ff;
   logic [5:0]           len6;
   logic [5:0]           idx6;
   logic [IDX_BITS-1:0]  idx;
   logic                 active;
   logic                 in_range;

   // The byte moves one cell further along the chain for every accepted word.
   always_ff @(posedge clock) begin
      if (shift_i) begin
         byte_ff <= byte_i;
      end
   end

   // This cell holds the byte POSITION words back; it lines up with pattern
   // byte length-1-POSITION and only takes part while POSITION < length.
   assign len6     = 6'(pattern_length_i);
   assign active   = len6 > POS;
   assign idx6     = len6 - 6'd1 - POS;
   assign in_range = idx6 < MAX_LEN;
   assign idx      = idx6[IDX_BITS-1:0];

   assign match_ok_o = !active || (in_range && (byte_ff == pattern_i[idx]));
   assign byte_o     = byte_ff;

endmodule

// ===== sv/soc_tally.sv =====
// Match gating, running count and the result output register.
// Depends on soc_pkg and the assertion macro header.
`include "substring_occurrence_counter_top_macros.svh"
module soc_tally #(
   parameter int MAX_PATTERN = 16,
   parameter int COUNT_BITS  = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  soc_pkg::step_type                    step_i,
   input  logic [soc_pkg::PATTERN_LEN_BITS-1:0] pattern_length_i,
   output logic                                 req_ready,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_match_found,
   output logic [soc_pkg::OCC_COUNT_BITS-1:0]   rsp_occurrence_count,
   output logic                                 rsp_count_final
);
   import soc_pkg::*;

   localparam int SEEN_BITS = $clog2(MAX_PATTERN + 1);
   localparam logic [SEEN_BITS-1:0]  SEEN_MAX  = SEEN_BITS'(MAX_PATTERN);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   logic [SEEN_BITS-1:0]      seen_ff, seen_in, seen_inc;
   logic [SEEN_BITS-1:0]      dist_ff, dist_in, dist_inc, dist_next;
   logic [COUNT_BITS-1:0]     count_ff, count_in, count_next;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_match_ff;
   logic [OCC_COUNT_BITS-1:0] rsp_count_ff;
   logic                      rsp_final_ff;
   logic [5:0]                len6;
   logic                      hit;

   // No word is taken while reset is held.
   assign req_ready = !reset && (!rsp_valid_ff || rsp_ready);

   assign seen_inc = (seen_ff < SEEN_MAX) ? seen_ff + SEEN_BITS'(1) : SEEN_MAX;
   assign dist_inc = (dist_ff < SEEN_MAX) ? dist_ff + SEEN_BITS'(1) : SEEN_MAX;
   assign len6     = 6'(pattern_length_i);

   // A window match counts only once enough bytes have arrived and the
   // window clears the previous counted occurrence.
   assign hit = step_i.window_match && (6'(seen_inc) >= len6) && (6'(dist_inc) >= len6);

   assign dist_next  = hit ? '0 : dist_inc;
   assign count_next = (hit && (count_ff != COUNT_MAX)) ? count_ff + COUNT_BITS'(1)
                                                        : count_ff;

   always_comb begin
      seen_in      = seen_ff;
      dist_in      = dist_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (step_i.accept) begin
         rsp_valid_in = 1'b1;
         if (step_i.last) begin
            seen_in  = '0;
            dist_in  = SEEN_MAX;
            count_in = '0;
         end else begin
            seen_in  = seen_inc;
            dist_in  = dist_next;
            count_in = count_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff      <= '0;
         dist_ff      <= SEEN_MAX;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seen_ff      <= seen_in;
         dist_ff      <= dist_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_i.accept) begin
         rsp_match_ff <= hit;
         rsp_count_ff <= OCC_COUNT_BITS'(count_next);
         rsp_final_ff <= step_i.last;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_match_found      = rsp_match_ff;
   assign rsp_occurrence_count = rsp_count_ff;
   assign rsp_count_final      = rsp_final_ff;

   `SOC_ASSERT_ALWAYS(a_seen_bounded, clock, reset, seen_ff <= SEEN_MAX)
   `SOC_ASSERT_NEXT(a_text_cleared, clock, reset, step_i.accept && step_i.last,
                    seen_ff == '0 && dist_ff == SEEN_MAX && count_ff == '0)
   `SOC_ASSERT_NEXT(a_hit_restarts_distance, clock, reset,
                    step_i.accept && hit && !step_i.last, dist_ff == '0 && count_ff != '0)
   `SOC_ASSERT_NEXT(a_no_accept_holds_count, clock, reset, !step_i.accept,
                    $stable(count_ff) && $stable(seen_ff))

endmodule

// ===== tb/substring_occurrence_counter_top_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for substring_occurrence_counter_top: random and directed
// text against a predictor of the non-overlapping count. Depends on soc_pkg and the RTL.

module substring_occurrence_counter_top_test;
   import soc_pkg::*;

   localparam int HALF_PERIOD      = 6;
   localparam int RESET_CYCLES     = 8;
   localparam int WINDOW_BYTES     = 16;
   localparam int HISTORY_DEPTH    = WINDOW_BYTES - 1;
   localparam int MAX_REPORTS      = 10;
   localparam int IDLE_PERCENT     = 34;
   localparam int STEADY_WORDS     = 256;
   localparam int RANDOM_SETTINGS  = 8;
   localparam int WORDS_PER_SETTING = 130;
   localparam int TAIL_CYCLES      = 4;
   localparam logic [OCC_COUNT_BITS-1:0] COUNT_CEILING = '1;

   // One word of text as it crosses the request channel.
   typedef struct packed {
      logic [BYTE_BITS-1:0] text_byte;
      logic                 end_of_text;
   } text_word_type;

   // The result that one word of text should produce.
   typedef struct packed {
      logic                      match_found;
      logic [OCC_COUNT_BITS-1:0] occurrence_count;
      logic                      count_final;
   } tally_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [BYTE_BITS-1:0]      req_text_byte = '0;
   logic                      req_end_of_text = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic                      rsp_match_found;
   logic [OCC_COUNT_BITS-1:0] rsp_occurrence_count;
   logic                      rsp_count_final;
   logic                      csr_write_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   // Words waiting for the driver, and the results still owed by the block.
   text_word_type pending_words[$];
   tally_type     expected_tallies[$];

   // Words handed to the driver and results taken by the monitor; the block is
   // idle whenever the two agree.
   int unsigned words_queued    = 0;
   int unsigned results_checked = 0;
   int unsigned failures        = 0;

   // When set, neither side idles.
   bit steady_flow = 1'b0;

   // The testbench's own copy of the configuration.
   logic [2*CSR_DATA_BITS-1:0]  pattern_bits = '0;
   logic [PATTERN_LEN_BITS-1:0] pattern_len  = '0;

   // Text state of the predictor: the previous bytes, newest first, the bytes
   // taken so far, the distance since the last counted match and the count.
   logic [BYTE_BITS-1:0]      recent_text [HISTORY_DEPTH];
   int unsigned               seen_bytes;
   int unsigned               match_gap;
   logic [OCC_COUNT_BITS-1:0] running_total;

   // Symbols from which the current pattern was built; random text is mostly
   // drawn from them so that matches are frequent.
   logic [BYTE_BITS-1:0] symbols [3];
   int unsigned          symbol_count = 1;

   substring_occurrence_counter_top i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_text_byte        (req_text_byte),
      .req_end_of_text      (req_end_of_text),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_match_found      (rsp_match_found),
      .rsp_occurrence_count (rsp_occurrence_count),
      .rsp_count_final      (rsp_count_final),
      .csr_write_en         (csr_write_en),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   function automatic logic [BYTE_BITS-1:0] pattern_byte(int unsigned idx);
      return pattern_bits[idx*BYTE_BITS +: BYTE_BITS];
   endfunction

   // Returns the text state to what it is after reset or after a final byte.
   function automatic void clear_text_state();
      for (int unsigned k = 0; k < HISTORY_DEPTH; k++) begin
         recent_text[k] = '0;
      end
      seen_bytes    = 0;
      match_gap     = WINDOW_BYTES;
      running_total = '0;
   endfunction

   // Works out the result of one word of text and advances the text state.
   // A window match is counted only when the whole pattern has arrived and the
   // window lies entirely after the end of the previous counted match.
   function automatic tally_type tally_word(text_word_type w);
      tally_type   r;
      int unsigned seen;
      int unsigned gap;
      int unsigned len;
      int unsigned k;
      logic        hit;
      len  = pattern_len;
      seen = (seen_bytes < WINDOW_BYTES) ? seen_bytes + 1 : WINDOW_BYTES;
      gap  = (match_gap < WINDOW_BYTES) ? match_gap + 1 : WINDOW_BYTES;
      hit  = 1'b0;
      if (len >= 1 && len <= WINDOW_BYTES && seen >= len && gap >= len) begin
         hit = (pattern_byte(len - 1) == w.text_byte);
         for (k = 1; k < len; k++) begin
            if (pattern_byte(len - 1 - k) != recent_text[k - 1]) begin
               hit = 1'b0;
            end
         end
      end
      if (hit) begin
         if (running_total != COUNT_CEILING) begin
            running_total = running_total + 1'b1;
         end
         gap = 0;
      end
      for (k = HISTORY_DEPTH - 1; k > 0; k--) begin
         recent_text[k] = recent_text[k - 1];
      end
      recent_text[0] = w.text_byte;
      seen_bytes     = seen;
      match_gap      = gap;
      r.match_found      = hit;
      r.occurrence_count = running_total;
      r.count_final      = w.end_of_text;
      if (w.end_of_text) begin
         clear_text_state();
      end
      return r;
   endfunction

   task automatic log_failure(string msg);
      failures++;
      if (failures <= MAX_REPORTS) begin
         $display("%s", msg);
      end
   endtask

   // Driver. A new word is presented only once the previous one has been
   // taken, so valid never drops while a word is waiting. Outside a steady
   // stretch the driver idles in about a third of the cycles.
   always @(posedge clock) begin : driver
      text_word_type next_word;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_words.size() != 0 &&
             (steady_flow || $urandom_range(99) >= IDLE_PERCENT)) begin
            next_word = pending_words.pop_front();
            req_valid       <= 1'b1;
            req_text_byte   <= next_word.text_byte;
            req_end_of_text <= next_word.end_of_text;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // The receiver stalls at random, except in a steady stretch.
   always @(posedge clock) begin : receiver
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // Monitor. Every accepted word of text is run through the predictor; every
   // accepted result is compared with the oldest expectation.
   always @(posedge clock) begin : monitor
      tally_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_tallies.push_back(
               tally_word(text_word_type'{req_text_byte, req_end_of_text}));
         end
         if (rsp_valid && rsp_ready) begin
            results_checked++;
            if (expected_tallies.size() == 0) begin
               log_failure($sformatf("result %0d arrived with nothing expected: %0b %0d %0b",
                  results_checked, rsp_match_found, rsp_occurrence_count,
                  rsp_count_final));
            end else begin
               want = expected_tallies.pop_front();
               if (rsp_match_found !== want.match_found ||
                   rsp_occurrence_count !== want.occurrence_count ||
                   rsp_count_final !== want.count_final) begin
                  log_failure($sformatf(
                     "result %0d wrong: match %0b count %0d final %0b, expected %0b %0d %0b",
                     results_checked, rsp_match_found, rsp_occurrence_count,
                     rsp_count_final, want.match_found, want.occurrence_count,
                     want.count_final));
               end
            end
         end
      end
   end

   task automatic queue_word(logic [BYTE_BITS-1:0] text_byte, logic end_of_text);
      pending_words.push_back(text_word_type'{text_byte, end_of_text});
      words_queued++;
   endtask

   // Waits until every word handed to the driver has produced its result.
   task automatic wait_drained();
      do @(posedge clock); while (results_checked != words_queued);
   endtask

   // Writes one register and keeps the predictor's copy in step. Only called
   // while the block is idle.
   task automatic write_register(logic [CSR_INDEX_BITS-1:0] index,
                                 logic [CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= data;
      case (index)
         CSR_PATTERN_LOW: begin
            pattern_bits[CSR_DATA_BITS-1:0] = data;
         end
         CSR_PATTERN_HIGH: begin
            pattern_bits[2*CSR_DATA_BITS-1:CSR_DATA_BITS] = data;
         end
         CSR_PATTERN_LENGTH: begin
            pattern_len = data[PATTERN_LEN_BITS-1:0];
         end
         default: begin
         end
      endcase
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Picks a fresh pattern and length and writes all three registers. Short
   // patterns over a small alphabet dominate; empty and overlong lengths and
   // the full window turn up too. Bytes beyond the length are pure noise, and
   // the length is written with random upper bits.
   task automatic choose_random_setting();
      logic [2*CSR_DATA_BITS-1:0] bits;
      logic [CSR_DATA_BITS-1:0]   len_data;
      int unsigned                r;
      int unsigned                len;
      symbol_count = $urandom_range(1, 3);
      for (int unsigned k = 0; k < 3; k++) begin
         symbols[k] = BYTE_BITS'($urandom_range(255));
      end
      r = $urandom_range(99);
      if (r < 8) begin
         len = 0;
      end else if (r < 16) begin
         len = $urandom_range(WINDOW_BYTES + 1, 31);
      end else if (r < 24) begin
         len = WINDOW_BYTES;
      end else if (r < 60) begin
         len = $urandom_range(1, 4);
      end else begin
         len = $urandom_range(1, WINDOW_BYTES);
      end
      for (int unsigned k = 0; k < WINDOW_BYTES; k++) begin
         bits[k*BYTE_BITS +: BYTE_BITS] = (k < len) ?
            symbols[$urandom_range(0, symbol_count - 1)] : BYTE_BITS'($urandom_range(255));
      end
      len_data = {$urandom(), $urandom()};
      len_data[PATTERN_LEN_BITS-1:0] = PATTERN_LEN_BITS'(len);
      write_register(CSR_PATTERN_LOW, bits[CSR_DATA_BITS-1:0]);
      write_register(CSR_PATTERN_HIGH, bits[2*CSR_DATA_BITS-1:CSR_DATA_BITS]);
      write_register(CSR_PATTERN_LENGTH, len_data);
   endtask

   // Queues one complete text. Most of it is whole or partial copies of the
   // pattern and pattern symbols, so that overlapping and back-to-back matches
   // are common; a little is arbitrary bytes.
   task automatic queue_random_text();
      logic [BYTE_BITS-1:0] body[$];
      int unsigned          target;
      int unsigned          span;
      int unsigned          n;
      int unsigned          r;
      target = ($urandom_range(9) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
      span = (pattern_len >= 1 && pattern_len <= WINDOW_BYTES) ?
             pattern_len : $urandom_range(1, WINDOW_BYTES);
      while (body.size() < target) begin
         r = $urandom_range(99);
         if (r < 45) begin
            n = (r < 30) ? span : $urandom_range(1, span);
            for (int unsigned k = 0; k < n; k++) begin
               body.push_back(pattern_byte(k));
            end
         end else if (r < 92) begin
            body.push_back(symbols[$urandom_range(0, symbol_count - 1)]);
         end else begin
            body.push_back(BYTE_BITS'($urandom_range(255)));
         end
      end
      for (int unsigned k = 0; k < target; k++) begin
         queue_word(body[k], k == target - 1);
      end
   endtask

   initial begin : stimulus
      int unsigned target;
      int unsigned midpoint;
      clear_text_state();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Empty pattern straight after reset: a single-byte text finds nothing.
      queue_word(8'h00, 1'b1);
      wait_drained();

      // One-byte pattern: every matching byte counts, including the last.
      write_register(CSR_PATTERN_LOW, 64'h0000_0000_0000_00FF);
      write_register(CSR_PATTERN_LENGTH, 64'd1);
      queue_word(8'hFF, 1'b0);
      queue_word(8'h00, 1'b0);
      queue_word(8'hFF, 1'b1);
      wait_drained();

      // Two equal bytes against a run of five: the first byte alone is too
      // short a text, and overlapping windows must not be counted twice.
      write_register(CSR_PATTERN_LOW, 64'h0000_0000_0000_6161);
      write_register(CSR_PATTERN_LENGTH, 64'd2);
      for (int unsigned k = 0; k < 5; k++) begin
         queue_word(8'h61, k == 4);
      end
      wait_drained();

      // Full sixteen-byte window, matched only by the final byte of the text.
      write_register(CSR_PATTERN_LOW, 64'h0807_0605_0403_0201);
      write_register(CSR_PATTERN_HIGH, 64'h100F_0E0D_0C0B_0A09);
      write_register(CSR_PATTERN_LENGTH, 64'd16);
      for (int unsigned k = 0; k < WINDOW_BYTES; k++) begin
         queue_word(pattern_byte(k), k == WINDOW_BYTES - 1);
      end
      wait_drained();

      // A length beyond the window never matches.
      write_register(CSR_PATTERN_LENGTH, 64'd31);
      queue_word(8'h01, 1'b1);
      wait_drained();

      // Long steady run: one text of matching bytes with a one-byte pattern,
      // so that every word is counted. Neither side idles in this stretch.
      steady_flow = 1'b1;
      write_register(CSR_PATTERN_LOW, {$urandom(), $urandom_range(255, 0) & 32'hFFFF_FF00} |
                     64'h5A);
      write_register(CSR_PATTERN_LENGTH, 64'd1);
      for (int unsigned k = 0; k < STEADY_WORDS; k++) begin
         queue_word(8'h5A, k == STEADY_WORDS - 1);
      end
      wait_drained();
      steady_flow = 1'b0;

      // Random settings, each with its own texts. Halfway through each the
      // sender holds back until every result owed so far has arrived.
      for (int unsigned s = 0; s < RANDOM_SETTINGS; s++) begin
         choose_random_setting();
         target   = words_queued + WORDS_PER_SETTING;
         midpoint = words_queued + WORDS_PER_SETTING / 2;
         while (words_queued < midpoint) begin
            queue_random_text();
         end
         wait_drained();
         while (words_queued < target) begin
            queue_random_text();
         end
         wait_drained();
      end

      // Allow a few more cycles so that any stray result is still caught.
      repeat (TAIL_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("PASS substring_occurrence_counter_top");
      end else begin
         $display("FAIL substring_occurrence_counter_top");
      end
      $finish;
   end

   // Generous bound on the whole run; a hang ends here.
   initial begin : watchdog
      #50_000_000;
      $display("FAIL substring_occurrence_counter_top");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+sv
sv/soc_pkg.sv
sv/soc_cell.sv
sv/soc_tally.sv
sv/substring_occurrence_counter_top.sv
tb/substring_occurrence_counter_top_test.sv
